/* hw/rtl/firq15r_pkg.sv */
package firq15r_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned CIDX_W   = 6;
    localparam int unsigned PROD_W   = 32;
    localparam int unsigned Q_SHIFT  = 15;
    localparam int unsigned S_TDATA_W = 24;

    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic step;
        logic last;
    } t_mac_ctl;

endpackage

/* hw/rtl/fir_filter_q15_ring_unit.sv */
// A sample transfer is filtered by the single shared multiply-accumulate, stepping once per
// tap; the input is held not ready until the result is registered on the output, so a new
// sample is taken only after that. A coefficient transfer gives no result and leaves the
// input ready. Reset (synchronous, active low) clears the sample ring and coefficient store
// through per-entry valid bits at once, and sets the write pointer to zero.
module fir_filter_q15_ring_unit #(
    parameter int unsigned TAPS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // [15:0] value, [21:16] coefficient_index, [23:22] zero
    input  logic [0:0]  i_s_axis_tuser,  // [0] operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata   // [15:0] filtered_sample
);

    localparam int unsigned AW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

    firq15r_pkg::t_state   r_state, n_state;
    logic [AW-1:0]         r_wpos, n_wpos;
    logic [AW-1:0]         r_rd, n_rd;
    logic [AW-1:0]         r_step, n_step;
    logic                  r_rd_vld;
    logic                  r_rd_last;
    logic                  r_fin, n_fin;
    logic                  r_out_valid, n_out_valid;
    firq15r_pkg::t_sample  r_out_data, n_out_data;

    logic                  s_xfer;
    logic                  m_xfer;
    logic                  filt_xfer;
    logic                  coef_we;
    logic [8:0]            cidx_ext;
    logic                  issue;
    firq15r_pkg::t_sample  in_value;
    firq15r_pkg::t_sample  ring_rdata;
    firq15r_pkg::t_sample  coef_rdata;
    firq15r_pkg::t_sample  acc;
    logic                  mac_done;
    firq15r_pkg::t_mac_ctl mac_ctl;

    assign in_value  = i_s_axis_tdata[15:0];
    assign cidx_ext  = 9'(i_s_axis_tdata[21:16]);
    assign s_xfer    = i_s_axis_tvalid & o_s_axis_tready;
    assign m_xfer    = o_m_axis_tvalid & i_m_axis_tready;
    assign filt_xfer = s_xfer & (i_s_axis_tuser[0] == firq15r_pkg::OP_FILTER);
    assign coef_we   = s_xfer & (i_s_axis_tuser[0] == firq15r_pkg::OP_COEF)
                     & (cidx_ext < 9'(TAPS));
    assign issue     = (r_state == firq15r_pkg::ST_RUN);

    assign mac_ctl.clear = filt_xfer;
    assign mac_ctl.step  = r_rd_vld;
    assign mac_ctl.last  = r_rd_last;

    firq15r_store #(
        .DEPTH (TAPS),
        .AW    (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (filt_xfer),
        .i_waddr (r_wpos),
        .i_wdata (in_value),
        .i_raddr (r_rd),
        .o_rdata (ring_rdata)
    );

    firq15r_store #(
        .DEPTH (TAPS),
        .AW    (AW)
    ) u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (coef_we),
        .i_waddr (AW'(i_s_axis_tdata[21:16])),
        .i_wdata (in_value),
        .i_raddr (r_step),
        .o_rdata (coef_rdata)
    );

    firq15r_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_sample (ring_rdata),
        .i_coef   (coef_rdata),
        .o_acc    (acc),
        .o_done   (mac_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= firq15r_pkg::ST_IDLE;
            r_wpos      <= '0;
            r_rd        <= '0;
            r_step      <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_last   <= 1'b0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wpos      <= n_wpos;
            r_rd        <= n_rd;
            r_step      <= n_step;
            r_rd_vld    <= issue;
            r_rd_last   <= issue & (r_step == LAST);
            r_fin       <= n_fin;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_wpos      = r_wpos;
        n_rd        = r_rd;
        n_step      = r_step;
        n_fin       = r_fin | mac_done;
        n_out_valid = r_out_valid & ~m_xfer;
        n_out_data  = r_out_data;
        o_s_axis_tready = 1'b0;
        case (r_state)
            firq15r_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (filt_xfer) begin
                    n_rd    = r_wpos;
                    n_step  = '0;
                    n_wpos  = (r_wpos == '0) ? LAST : r_wpos - AW'(1);
                    n_fin   = 1'b0;
                    n_state = firq15r_pkg::ST_RUN;
                end
            end
            firq15r_pkg::ST_RUN: begin
                n_rd   = (r_rd == LAST) ? '0 : r_rd + AW'(1);
                n_step = r_step + AW'(1);
                if (r_step == LAST) begin
                    n_state = firq15r_pkg::ST_WAIT;
                end
            end
            firq15r_pkg::ST_WAIT: begin
                if (r_fin && (!r_out_valid || i_m_axis_tready)) begin
                    n_out_valid = 1'b1;
                    n_out_data  = acc;
                    n_fin       = 1'b0;
                    n_state     = firq15r_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = firq15r_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

/* hw/rtl/firq15r_store.sv */
module firq15r_store #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  firq15r_pkg::t_sample     i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output firq15r_pkg::t_sample     o_rdata
);

    firq15r_pkg::t_sample r_mem [DEPTH];
    logic [DEPTH-1:0]     r_valid;
    firq15r_pkg::t_sample r_rdata;
    logic                 r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

/* hw/rtl/firq15r_mac.sv */
module firq15r_mac (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  firq15r_pkg::t_mac_ctl    i_ctl,
    input  firq15r_pkg::t_sample     i_sample,
    input  firq15r_pkg::t_sample     i_coef,
    output firq15r_pkg::t_sample     o_acc,
    output logic                     o_done
);

    logic signed [firq15r_pkg::PROD_W-1:0] r_prod;
    logic                                  r_pvld;
    logic                                  r_plast;
    firq15r_pkg::t_sample                  r_acc;
    logic                                  r_done;

    always_ff @(posedge i_clk) begin
        r_prod <= i_sample * i_coef;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld  <= 1'b0;
            r_plast <= 1'b0;
            r_done  <= 1'b0;
            r_acc   <= '0;
        end else begin
            r_pvld  <= i_ctl.step;
            r_plast <= i_ctl.step & i_ctl.last;
            r_done  <= r_pvld & r_plast;
            if (i_ctl.clear) begin
                r_acc <= '0;
            end else if (r_pvld) begin
                r_acc <= r_acc + r_prod[firq15r_pkg::Q_SHIFT +: firq15r_pkg::SAMPLE_W];
            end
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

/* hw/rtl/firq15r_checker.sv */
module firq15r_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [23:0] i_s_axis_tdata,
    input logic [0:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata
);

    logic s_xfer;
    assign s_xfer = i_s_axis_tvalid & o_s_axis_tready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output transfer dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("output data changed while stalled");

    a_filter_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer && (i_s_axis_tuser[0] == firq15r_pkg::OP_FILTER) |=> !o_s_axis_tready)
        else $error("input ready right after a sample transfer");

    a_coef_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer && (i_s_axis_tuser[0] == firq15r_pkg::OP_COEF) |=> o_s_axis_tready)
        else $error("coefficient transfer held the input");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> o_s_axis_tready)
        else $error("result presented while still filtering");

endmodule

bind fir_filter_q15_ring_unit firq15r_checker u_firq15r_checker (.*);
